// ----- rtl/core/plfl_pkg.sv -----
// Shared types, codes and helpers for the priority level FIFO list.
// Used by plfl_occ_map, plfl_core and priority_level_fifo_list. No dependencies.
package plfl_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int BASE_LEVELS_DEF = 256;
    localparam int OCC_BITS        = 32;

    localparam logic [2:0] ACT_ADD       = 3'd0;
    localparam logic [2:0] ACT_REMOVE    = 3'd1;
    localparam logic [2:0] ACT_FIND      = 3'd2;
    localparam logic [2:0] ACT_FIRST     = 3'd3;
    localparam logic [2:0] ACT_NEXT      = 3'd4;
    localparam logic [2:0] ACT_NEXT_LVL  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] entry;
        logic [7:0] priority_req;
        logic       boost;
        logic       want_head;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_entry;
        logic [8:0] found_level;
    } out_t;

    // Position of the lowest set bit, with a found flag on top.
    function automatic logic [5:0] lowest_set(input logic [OCC_BITS-1:0] w);
        logic [5:0] r;
        r = '0;
        for (int i = OCC_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/plfl_occ_map.sv -----
// Level occupancy bitmap: a word memory of 32-bit rows plus a row summary.
// Depends on plfl_pkg. A row whose summary bit is clear reads as all zero.
module plfl_occ_map #(
    parameter int WW = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [WW-1:0]                 rd_addr,
    output logic [plfl_pkg::OCC_BITS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [WW-1:0]                 wr_addr,
    input  logic [plfl_pkg::OCC_BITS-1:0] wr_data,
    output logic [(1<<WW)-1:0]            summary
);

    localparam int ROWS = 1 << WW;

    logic [plfl_pkg::OCC_BITS-1:0] mem [ROWS];
    logic [plfl_pkg::OCC_BITS-1:0] q_reg;
    logic                          row_ok_reg;
    logic [ROWS-1:0]               summary_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            summary_reg <= '0;
            row_ok_reg  <= 1'b0;
        end
        else begin
            if (wr_en) begin
                summary_reg[wr_addr] <= |wr_data;
            end
            if (rd_en) begin
                row_ok_reg <= summary_reg[rd_addr];
            end
        end
    end

    assign rd_data = row_ok_reg ? q_reg : '0;
    assign summary = summary_reg;

endmodule

// ----- rtl/core/plfl_core.sv -----
// Operation sequencer with the entry link memory and the level head/tail memory.
// Depends on plfl_pkg and plfl_occ_map.
module plfl_core #(
    parameter int ENTRIES     = plfl_pkg::ENTRIES_DEF,
    parameter int BASE_LEVELS = plfl_pkg::BASE_LEVELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  plfl_pkg::in_t   req,
    output logic            res_valid,
    input  logic            res_ready,
    output plfl_pkg::out_t  res
);

    localparam int EW      = $clog2(ENTRIES);
    localparam int LKW     = $clog2(ENTRIES + 1);
    localparam int NLEVELS = 2 * BASE_LEVELS;
    localparam int NW      = (NLEVELS + plfl_pkg::OCC_BITS - 1) / plfl_pkg::OCC_BITS;
    localparam int WW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int PLW     = WW + 5;
    localparam int LDEPTH  = 1 << PLW;
    localparam int ROWS    = 1 << WW;
    localparam int EWD     = 2 * LKW + PLW + 2;
    localparam int N_HI    = EWD - 1;
    localparam int N_LO    = EWD - LKW;
    localparam int P_HI    = N_LO - 1;
    localparam int P_LO    = N_LO - LKW;
    localparam int L_HI    = P_LO - 1;
    localparam int L_LO    = 2;
    localparam logic [LKW-1:0] NIL = LKW'(ENTRIES);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_NEXT_RD = 22'h000002,
        S_ANS     = 22'h000004,
        S_FIND    = 22'h000008,
        S_NL_E    = 22'h000010,
        S_NL_L    = 22'h000020,
        S_RM_E    = 22'h000040,
        S_RM_P    = 22'h000080,
        S_RM_PW   = 22'h000100,
        S_RM_N    = 22'h000200,
        S_RM_NW   = 22'h000400,
        S_RM_L    = 22'h000800,
        S_RM_OC   = 22'h001000,
        S_RM_LW   = 22'h002000,
        S_ADD_L   = 22'h004000,
        S_ADD_W2  = 22'h008000,
        S_ADD_H   = 22'h010000,
        S_ADD_P   = 22'h020000,
        S_ADD_PW  = 22'h040000,
        S_ADD_E   = 22'h080000,
        S_ADD_NW  = 22'h100000,
        S_DONE    = 22'h200000
    } state_t;

    // Entry memory: next, prev, level, head mark, tail mark.
    logic [EWD-1:0]   ent_mem [ENTRIES];
    logic [EWD-1:0]   ent_q;
    logic             ent_re, ent_we;
    logic [EW-1:0]    ent_ra, ent_wa;
    logic [EWD-1:0]   ent_wd;

    // Level memory: head and tail entry of each level.
    logic [2*EW-1:0]  lv_mem [LDEPTH];
    logic [2*EW-1:0]  lv_q;
    logic             lv_re, lv_we;
    logic [PLW-1:0]   lv_ra, lv_wa;
    logic [2*EW-1:0]  lv_wd;

    logic                          oc_re, oc_we;
    logic [WW-1:0]                 oc_ra, oc_wa;
    logic [plfl_pkg::OCC_BITS-1:0] oc_q, oc_wd;
    logic [ROWS-1:0]               summary;

    state_t          state_reg, state_next;
    logic [EW-1:0]   e_reg, e_next;
    logic [EW-1:0]   tgt_reg, tgt_next;
    logic [PLW-1:0]  lvl_reg, lvl_next;
    logic            want_reg, want_next;
    logic [LKW-1:0]  pv_reg, pv_next;
    logic [LKW-1:0]  nx_reg, nx_next;
    logic [LKW-1:0]  pred_reg, pred_next;
    logic            hm_reg, hm_next;
    logic            tm_reg, tm_next;
    logic            occ_reg, occ_next;
    logic [WW-1:0]   w2_reg, w2_next;
    logic [LKW-1:0]  ls_reg, ls_next;
    logic [ENTRIES-1:0] present_reg, present_next;
    plfl_pkg::out_t  res_reg, res_next;

    logic [EW-1:0]   ein;
    logic            oob, pres, prbad;
    logic [PLW-1:0]  lvlin;
    logic [WW-1:0]   wcur;
    logic [4:0]      bcur;
    logic [plfl_pkg::OCC_BITS-1:0] bitmask, above;
    logic [5:0]      lo_above, lo_row;
    logic            w2_found;
    logic [WW-1:0]   w2_idx;

    always_ff @(posedge clk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            ent_q <= ent_mem[ent_ra];
        end
        if (lv_we) begin
            lv_mem[lv_wa] <= lv_wd;
        end
        if (lv_re) begin
            lv_q <= lv_mem[lv_ra];
        end
    end

    plfl_occ_map #(
        .WW(WW)
    ) u_occ (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (oc_re),
        .rd_addr (oc_ra),
        .rd_data (oc_q),
        .wr_en   (oc_we),
        .wr_addr (oc_wa),
        .wr_data (oc_wd),
        .summary (summary)
    );

    assign ein   = EW'(req.entry);
    assign oob   = 32'(req.entry) >= ENTRIES;
    assign pres  = !oob && present_reg[ein];
    assign prbad = 32'(req.priority_req) >= BASE_LEVELS;
    assign lvlin = PLW'(req.priority_req) + (req.boost ? PLW'(BASE_LEVELS) : '0);

    assign wcur    = lvl_reg[PLW-1:5];
    assign bcur    = lvl_reg[4:0];
    assign bitmask = plfl_pkg::OCC_BITS'(1) << bcur;
    assign above   = oc_q & ~((plfl_pkg::OCC_BITS'(2) << bcur) - plfl_pkg::OCC_BITS'(1));
    assign lo_above = plfl_pkg::lowest_set(above);
    assign lo_row   = plfl_pkg::lowest_set(oc_q);

    // Nearest occupied row above the current one.
    always_comb begin
        w2_found = 1'b0;
        w2_idx   = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (summary[i] && (WW'(i) > wcur)) begin
                w2_found = 1'b1;
                w2_idx   = WW'(i);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        e_next       = e_reg;
        tgt_next     = tgt_reg;
        lvl_next     = lvl_reg;
        want_next    = want_reg;
        pv_next      = pv_reg;
        nx_next      = nx_reg;
        pred_next    = pred_reg;
        hm_next      = hm_reg;
        tm_next      = tm_reg;
        occ_next     = occ_reg;
        w2_next      = w2_reg;
        ls_next      = ls_reg;
        present_next = present_reg;
        res_next     = res_reg;
        ent_re = 1'b0; ent_ra = '0;
        ent_we = 1'b0; ent_wa = '0; ent_wd = '0;
        lv_re  = 1'b0; lv_ra  = '0;
        lv_we  = 1'b0; lv_wa  = '0; lv_wd  = '0;
        oc_re  = 1'b0; oc_ra  = '0;
        oc_we  = 1'b0; oc_wa  = '0; oc_wd  = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    e_next    = ein;
                    lvl_next  = lvlin;
                    want_next = req.want_head;
                    res_next  = '{plfl_pkg::ST_ERROR, 6'd0, 9'd0};
                    state_next = S_DONE;
                    unique case (req.action)
                        plfl_pkg::ACT_ADD: begin
                            if (!(oob || pres || prbad)) begin
                                res_next = '{plfl_pkg::ST_OK, req.entry, 9'(lvlin)};
                                lv_re = 1'b1; lv_ra = lvlin;
                                oc_re = 1'b1; oc_ra = lvlin[PLW-1:5];
                                state_next = S_ADD_L;
                            end
                        end
                        plfl_pkg::ACT_REMOVE: begin
                            if (pres) begin
                                ent_re = 1'b1; ent_ra = ein;
                                state_next = S_RM_E;
                            end
                        end
                        plfl_pkg::ACT_FIND: begin
                            if (!prbad) begin
                                lv_re = 1'b1; lv_ra = lvlin;
                                oc_re = 1'b1; oc_ra = lvlin[PLW-1:5];
                                state_next = S_FIND;
                            end
                        end
                        plfl_pkg::ACT_FIRST: begin
                            if (ls_reg == NIL) begin
                                res_next = '{plfl_pkg::ST_NONE, 6'd0, 9'd0};
                            end
                            else begin
                                tgt_next = EW'(ls_reg);
                                ent_re = 1'b1; ent_ra = EW'(ls_reg);
                                state_next = S_ANS;
                            end
                        end
                        plfl_pkg::ACT_NEXT: begin
                            if (pres) begin
                                ent_re = 1'b1; ent_ra = ein;
                                state_next = S_NEXT_RD;
                            end
                        end
                        plfl_pkg::ACT_NEXT_LVL: begin
                            if (pres) begin
                                ent_re = 1'b1; ent_ra = ein;
                                state_next = S_NL_E;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_NEXT_RD: begin
                if (ent_q[N_HI:N_LO] == NIL) begin
                    res_next = '{plfl_pkg::ST_NONE, 6'd0, 9'd0};
                    state_next = S_DONE;
                end
                else begin
                    tgt_next = EW'(ent_q[N_HI:N_LO]);
                    ent_re = 1'b1; ent_ra = EW'(ent_q[N_HI:N_LO]);
                    state_next = S_ANS;
                end
            end
            S_ANS: begin
                res_next = '{plfl_pkg::ST_OK, 6'(tgt_reg), 9'(ent_q[L_HI:L_LO])};
                state_next = S_DONE;
            end
            S_FIND: begin
                if (!oc_q[bcur]) begin
                    res_next = '{plfl_pkg::ST_NONE, 6'd0, 9'd0};
                    state_next = S_DONE;
                end
                else begin
                    tgt_next = want_reg ? lv_q[2*EW-1:EW] : lv_q[EW-1:0];
                    ent_re = 1'b1;
                    ent_ra = want_reg ? lv_q[2*EW-1:EW] : lv_q[EW-1:0];
                    state_next = S_ANS;
                end
            end
            S_NL_E: begin
                if (!ent_q[1]) begin
                    state_next = S_DONE;
                end
                else begin
                    lv_re = 1'b1; lv_ra = ent_q[L_HI:L_LO];
                    state_next = S_NL_L;
                end
            end
            S_NL_L: begin
                ent_re = 1'b1; ent_ra = lv_q[EW-1:0];
                state_next = S_NEXT_RD;
            end
            S_RM_E: begin
                pv_next  = ent_q[P_HI:P_LO];
                nx_next  = ent_q[N_HI:N_LO];
                lvl_next = ent_q[L_HI:L_LO];
                hm_next  = ent_q[1];
                tm_next  = ent_q[0];
                present_next[e_reg] = 1'b0;
                res_next = '{plfl_pkg::ST_OK, 6'(e_reg), 9'(ent_q[L_HI:L_LO])};
                state_next = S_RM_P;
            end
            S_RM_P: begin
                if (pv_reg != NIL) begin
                    ent_re = 1'b1; ent_ra = EW'(pv_reg);
                    state_next = S_RM_PW;
                end
                else begin
                    ls_next = nx_reg;
                    state_next = S_RM_N;
                end
            end
            S_RM_PW: begin
                ent_we = 1'b1; ent_wa = EW'(pv_reg);
                ent_wd = {nx_reg, ent_q[P_HI:P_LO], ent_q[L_HI:L_LO], ent_q[1],
                          ent_q[0] | (tm_reg & ~hm_reg)};
                state_next = S_RM_N;
            end
            S_RM_N: begin
                if (nx_reg != NIL) begin
                    ent_re = 1'b1; ent_ra = EW'(nx_reg);
                    state_next = S_RM_NW;
                end
                else begin
                    state_next = S_RM_L;
                end
            end
            S_RM_NW: begin
                ent_we = 1'b1; ent_wa = EW'(nx_reg);
                ent_wd = {ent_q[N_HI:N_LO], pv_reg, ent_q[L_HI:L_LO],
                          ent_q[1] | (hm_reg & ~tm_reg), ent_q[0]};
                state_next = S_RM_L;
            end
            S_RM_L: begin
                if (hm_reg && tm_reg) begin
                    oc_re = 1'b1; oc_ra = wcur;
                    state_next = S_RM_OC;
                end
                else if (hm_reg || tm_reg) begin
                    lv_re = 1'b1; lv_ra = lvl_reg;
                    state_next = S_RM_LW;
                end
                else begin
                    state_next = S_DONE;
                end
            end
            S_RM_OC: begin
                oc_we = 1'b1; oc_wa = wcur; oc_wd = oc_q & ~bitmask;
                state_next = S_DONE;
            end
            S_RM_LW: begin
                lv_we = 1'b1; lv_wa = lvl_reg;
                lv_wd = hm_reg ? {EW'(nx_reg), lv_q[EW-1:0]} : {lv_q[2*EW-1:EW], EW'(pv_reg)};
                state_next = S_DONE;
            end
            S_ADD_L: begin
                lv_we = 1'b1; lv_wa = lvl_reg;
                if (oc_q[bcur]) begin
                    occ_next  = 1'b1;
                    pred_next = LKW'(lv_q[EW-1:0]);
                    hm_next   = 1'b0;
                    tm_next   = 1'b1;
                    lv_wd = {lv_q[2*EW-1:EW], e_reg};
                    state_next = S_ADD_P;
                end
                else begin
                    occ_next = 1'b0;
                    hm_next  = 1'b1;
                    tm_next  = 1'b1;
                    lv_wd = {e_reg, e_reg};
                    oc_we = 1'b1; oc_wa = wcur; oc_wd = oc_q | bitmask;
                    if (lo_above[5]) begin
                        lv_re = 1'b1; lv_ra = {wcur, lo_above[4:0]};
                        state_next = S_ADD_H;
                    end
                    else if (w2_found) begin
                        w2_next = w2_idx;
                        oc_re = 1'b1; oc_ra = w2_idx;
                        state_next = S_ADD_W2;
                    end
                    else begin
                        pred_next = NIL;
                        state_next = S_ADD_P;
                    end
                end
            end
            S_ADD_W2: begin
                lv_re = 1'b1; lv_ra = {w2_reg, lo_row[4:0]};
                state_next = S_ADD_H;
            end
            S_ADD_H: begin
                pred_next = LKW'(lv_q[EW-1:0]);
                state_next = S_ADD_P;
            end
            S_ADD_P: begin
                if (pred_reg == NIL) begin
                    nx_next = ls_reg;
                    ls_next = LKW'(e_reg);
                    state_next = S_ADD_E;
                end
                else begin
                    ent_re = 1'b1; ent_ra = EW'(pred_reg);
                    state_next = S_ADD_PW;
                end
            end
            S_ADD_PW: begin
                nx_next = ent_q[N_HI:N_LO];
                ent_we = 1'b1; ent_wa = EW'(pred_reg);
                ent_wd = {LKW'(e_reg), ent_q[P_HI:P_LO], ent_q[L_HI:L_LO], ent_q[1],
                          ent_q[0] & ~occ_reg};
                state_next = S_ADD_E;
            end
            S_ADD_E: begin
                ent_we = 1'b1; ent_wa = e_reg;
                ent_wd = {nx_reg, pred_reg, lvl_reg, hm_reg, tm_reg};
                present_next[e_reg] = 1'b1;
                if (nx_reg != NIL) begin
                    ent_re = 1'b1; ent_ra = EW'(nx_reg);
                    state_next = S_ADD_NW;
                end
                else begin
                    state_next = S_DONE;
                end
            end
            S_ADD_NW: begin
                ent_we = 1'b1; ent_wa = EW'(nx_reg);
                ent_wd = {ent_q[N_HI:N_LO], LKW'(e_reg), ent_q[L_HI:L_LO], ent_q[1], ent_q[0]};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            ls_reg      <= NIL;
            present_reg <= '0;
        end
        else begin
            state_reg   <= state_next;
            ls_reg      <= ls_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge clk) begin
        e_reg    <= e_next;
        tgt_reg  <= tgt_next;
        lvl_reg  <= lvl_next;
        want_reg <= want_next;
        pv_reg   <= pv_next;
        nx_reg   <= nx_next;
        pred_reg <= pred_next;
        hm_reg   <= hm_next;
        tm_reg   <= tm_next;
        occ_reg  <= occ_next;
        w2_reg   <= w2_next;
        res_reg  <= res_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ----- rtl/core/priority_level_fifo_list.sv -----
// Top level of the priority level FIFO list: output register around plfl_core.
// Depends on plfl_pkg and plfl_core.
//
// This block keeps up to ENTRIES entries in one linked list ordered by descending
// effective level (base priority, plus BASE_LEVELS when boost is set), first-in
// first-out within a level, and performs one operation per input transfer: add,
// remove, find level head or tail, first, next, and next lower level. Each input
// transfer yields exactly one result transfer carrying a status and, on success,
// an entry and its level. Operations run one at a time through a sequencer that
// reads and rewrites a registered-read entry link memory, a level head/tail
// memory and a level occupancy bitmap. Errors and a first on an empty list
// finish soonest; a remove that relinks both neighbors and updates its level
// and the longest add pass through the most states, and every result then
// passes through the output register. Add is shortest into an empty list, longer
// when it has a predecessor or a successor to relink, and longest when the nearest
// occupied level above lies in a higher 32-level bitmap row. A new input
// transfer is taken while a finished result still waits in the output register.
// No clearing pass is needed after reset.
module priority_level_fifo_list #(
    parameter int ENTRIES     = plfl_pkg::ENTRIES_DEF,
    parameter int BASE_LEVELS = plfl_pkg::BASE_LEVELS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  plfl_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output plfl_pkg::out_t out_data
);

    logic           res_valid;
    logic           res_ready;
    plfl_pkg::out_t res;
    logic           out_valid_reg;
    plfl_pkg::out_t out_data_reg;

    plfl_core #(
        .ENTRIES     (ENTRIES),
        .BASE_LEVELS (BASE_LEVELS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // The core hands over its result whenever the output register is free or
    // is being emptied in this same cycle.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
